>>> rtl/enfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfa_pkg
// Shared constants, types and codes of the epsilon-NFA string acceptor.
// ----------------------------------------------------------------------------
package enfa_pkg;

    localparam int NUM_STATES  = 16;
    localparam int MAX_TRANS   = 64;
    localparam int SYMBOL_BITS = 8;

    localparam int STATE_W   = $clog2(NUM_STATES);
    localparam int IDX_W     = $clog2(MAX_TRANS);
    localparam int CNT_W     = $clog2(MAX_TRANS + 1);
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [SYMBOL_BITS-1:0] EPS_RESET = SYMBOL_BITS'(42);

    typedef logic [NUM_STATES-1:0] t_set;

    typedef struct packed {
        logic [STATE_W-1:0]     from_state;
        logic [STATE_W-1:0]     to_state;
        logic [SYMBOL_BITS-1:0] symbol;
    } t_entry;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_FEED = 2'd1,
        CMD_END  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EPS    = 2'd0,
        CFG_START  = 2'd1,
        CFG_ACCEPT = 2'd2,
        CFG_USED   = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOS,
        ST_STEP,
        ST_FIN
    } t_state;

endpackage

>>> rtl/enfa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfa_in_if
// Request channel: load entry, feed symbol or end of string.
// ----------------------------------------------------------------------------
interface enfa_in_if import enfa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       cmd;
    logic [IDX_W-1:0]       entry_index;
    logic [STATE_W-1:0]     from_state;
    logic [STATE_W-1:0]     to_state;
    logic [SYMBOL_BITS-1:0] symbol;

    modport source (output valid, cmd, entry_index, from_state, to_state, symbol,
                    input ready);
    modport sink   (input valid, cmd, entry_index, from_state, to_state, symbol,
                    output ready);
endinterface

>>> rtl/enfa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfa_out_if
// Result channel: acceptance of the string just ended.
// ----------------------------------------------------------------------------
interface enfa_out_if import enfa_pkg::*; ();
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, accepted, input ready);
    modport sink   (input valid, accepted, output ready);
endinterface

>>> rtl/enfa_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfa_table
// Transition table memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module enfa_table import enfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [MAX_TRANS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/epsilon_nfa_string_acceptor.sv
`timescale 1ns / 1ps
// Sequence: load writes one entry; feed and end scan the entries in use in closure
//   passes while the set grows (<= 15 growing passes); a feed then runs a step pass.
// Throughput: one request at a time; table scans run at one entry per cycle
//   through the single read port of the table memory.
// Reset: synchronous active low; clears control, eps code 42, masks and count 0.
// A pending result does not block loads or feeds, only the next end.
// ----------------------------------------------------------------------------
// epsilon_nfa_string_acceptor
// Epsilon-NFA simulator over a symbol stream with a loadable transition table.
// ----------------------------------------------------------------------------
module epsilon_nfa_string_acceptor import enfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    enfa_in_if.sink              i_in,
    enfa_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_dvld, n_dvld;
    logic                   r_grew, n_grew;
    logic                   r_is_end, n_is_end;
    t_set                   r_set, n_set;
    t_set                   r_next, n_next;
    t_set                   r_active, n_active;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic                   r_out_vld, n_out_vld;
    logic                   r_out_acc, n_out_acc;

    logic [SYMBOL_BITS-1:0] r_eps, n_eps;
    t_set                   r_start, n_start;
    t_set                   r_accept, n_accept;
    logic [CNT_W-1:0]       r_used, n_used;

    logic                   w_we;
    logic                   w_issue;
    t_entry                 w_wdata;
    t_entry                 w_rd;
    logic [CNT_W-1:0]       w_used_in;

    assign w_wdata = '{from_state: i_in.from_state, to_state: i_in.to_state,
                       symbol: i_in.symbol};

    enfa_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in.entry_index),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rd)
    );

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_vld;
    assign o_out.accepted = r_out_acc;

    assign w_issue   = (r_idx < r_used);
    assign w_used_in = i_cfg_data[CNT_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_dvld    = 1'b0;
        n_grew    = r_grew;
        n_is_end  = r_is_end;
        n_set     = r_set;
        n_next    = r_next;
        n_active  = r_active;
        n_sym     = r_sym;
        n_out_vld = r_out_vld;
        n_out_acc = r_out_acc;
        n_eps     = r_eps;
        n_start   = r_start;
        n_accept  = r_accept;
        n_used    = r_used;
        w_we      = 1'b0;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.cmd == CMD_LOAD) begin
                        w_we = 1'b1;
                    end else if (i_in.cmd == CMD_FEED || i_in.cmd == CMD_END) begin
                        n_set    = r_active;
                        n_sym    = i_in.symbol;
                        n_is_end = (i_in.cmd == CMD_END);
                        n_idx    = '0;
                        n_grew   = 1'b0;
                        n_state  = ST_CLOS;
                    end
                end
            end
            ST_CLOS: begin
                if (w_issue) begin
                    n_idx  = r_idx + CNT_W'(1);
                    n_dvld = 1'b1;
                end
                // epsilon move into a state not yet in the set
                if (r_dvld && w_rd.symbol == r_eps && r_set[w_rd.from_state]
                        && !r_set[w_rd.to_state]) begin
                    n_set[w_rd.to_state] = 1'b1;
                    n_grew               = 1'b1;
                end
                if (!w_issue && !r_dvld) begin
                    n_idx = '0;
                    if (r_grew) begin
                        n_grew = 1'b0;
                    end else if (r_is_end) begin
                        n_state = ST_FIN;
                    end else begin
                        n_next  = '0;
                        n_state = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                if (w_issue) begin
                    n_idx  = r_idx + CNT_W'(1);
                    n_dvld = 1'b1;
                end
                if (r_dvld && w_rd.symbol == r_sym && r_set[w_rd.from_state]) begin
                    n_next[w_rd.to_state] = 1'b1;
                end
                if (!w_issue && !r_dvld) begin
                    n_active = r_next;
                    n_state  = ST_IDLE;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out_acc = |(r_set & r_accept);
                    n_active  = r_start;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EPS: begin
                    n_eps = i_cfg_data[SYMBOL_BITS-1:0];
                end
                CFG_START: begin
                    n_start  = i_cfg_data[NUM_STATES-1:0];
                    n_active = i_cfg_data[NUM_STATES-1:0];
                end
                CFG_ACCEPT: begin
                    n_accept = i_cfg_data[NUM_STATES-1:0];
                end
                CFG_USED: begin
                    n_used = (w_used_in > CNT_W'(MAX_TRANS)) ? CNT_W'(MAX_TRANS)
                                                              : w_used_in;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_dvld    <= 1'b0;
            r_grew    <= 1'b0;
            r_is_end  <= 1'b0;
            r_active  <= '0;
            r_out_vld <= 1'b0;
            r_eps     <= EPS_RESET;
            r_start   <= '0;
            r_accept  <= '0;
            r_used    <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_dvld    <= n_dvld;
            r_grew    <= n_grew;
            r_is_end  <= n_is_end;
            r_active  <= n_active;
            r_out_vld <= n_out_vld;
            r_eps     <= n_eps;
            r_start   <= n_start;
            r_accept  <= n_accept;
            r_used    <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set     <= n_set;
        r_next    <= n_next;
        r_sym     <= n_sym;
        r_out_acc <= n_out_acc;
    end

endmodule

>>> rtl/enfa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfa_checker
// Port-level checks of the epsilon-NFA string acceptor.
// ----------------------------------------------------------------------------
module enfa_checker import enfa_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [CMD_W-1:0] i_in_cmd,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_accepted
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_accepted))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_cmd != CMD_FEED && i_in_cmd != CMD_END)
            |=> i_in_ready)
        else $error("load or unknown request did not return to ready");

endmodule

bind epsilon_nfa_string_acceptor enfa_checker u_enfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_cmd       (i_in.cmd),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_accepted (o_out.accepted)
);
